FILE: rtl/dlts_pkg.sv
// Shared types and constants of the delta-list task scheduler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dlts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_MS_DEF   = 10;
    localparam int MS_W          = 32;
    localparam int TAG_W         = 8;
    localparam int ID_W          = 8;
    localparam int CMD_W         = 3;

    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TAG_W-1:0] task_tag;
        logic [MS_W-1:0]  delay_ms;
        logic [MS_W-1:0]  repeat_ms;
        logic [ID_W-1:0]  delete_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  assigned_id;
        logic             ran;
        logic [TAG_W-1:0] ran_tag;
        logic             deleted;
    } t_out_item;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_TICK,
        DP_CLEAR,
        DP_POP,
        DP_MUL,
        DP_DIV_START,
        DP_DIV_STEP,
        DP_SCAN_STEP,
        DP_INSERT,
        DP_DEL_INIT,
        DP_DEL_STEP,
        DP_DEL_REMOVE,
        DP_DEL_FOLD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             tag_zero;
        logic             full;
        logic             count_zero;
        logic             head_ready;
        logic             period_zero;
        logic             div_last;
        logic             scan_stop;
        logic             del_id_zero;
        logic             del_end;
        logic             del_match;
        t_out_item        res;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/dlts_chan_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is set at instantiation; no package dependency.
`default_nettype none

interface dlts_chan_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/delta_list_task_scheduler_top.sv
// Top level of the delta-list task scheduler: sequencer plus entry datapath.
// Depends on dlts_pkg, dlts_chan_if, dlts_ctrl, dlts_datapath and dlts_div.
`default_nettype none

// Timer queue of up to MAX_TASKS entries kept in due-time order, each holding
// its delay relative to the entry ahead, so a tick beat only counts the head
// down. One input beat carries a command (tick, add, dispatch, delete, clear)
// and yields exactly one result beat. Beats are handled one at a time; the
// result waits in an output register, so the next command is taken while it
// is still unclaimed. An accepted add walks past the entries ahead of its
// insert point, at most MAX_TASKS - 1 of them, and so does a dispatch that
// re-adds a periodic entry. The conversion of milliseconds to ticks is a
// reciprocal multiply followed by one remainder correction, and the insert
// walk reads one entry per cycle. Delete walks one entry per cycle to the
// match. A finished command whose result finds the previous one still
// unclaimed holds until the receiver takes it. Clear keeps the ID counter;
// IDs run from 1 to 255 and wrap past 0.

module delta_list_task_scheduler_top
    import dlts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TICK_MS   = TICK_MS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dlts_chan_if.sink   i_in_ch,
    dlts_chan_if.source o_out_ch
);

    t_dp_ctl  dp_ctl;
    t_dp_sts  dp_sts;
    t_in_item in_item;

    assign in_item = i_in_ch.data;

    // sequencer: owns both handshakes and the result beat register
    dlts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch),
        .i_sts    (dp_sts),
        .o_ctl    (dp_ctl)
    );

    // entry table, walk logic and tick conversion
    dlts_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TICK_MS   (TICK_MS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dp_ctl),
        .i_item  (in_item),
        .o_sts   (dp_sts)
    );

endmodule

`default_nettype wire

FILE: rtl/dlts_div.sv
// Divider by a constant: reciprocal multiply, remainder, one correction; three steps.
// Depends on dlts_pkg for the operand width.
`default_nettype none

module dlts_div
    import dlts_pkg::*;
#(
    parameter int DIVISOR = TICK_MS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire logic            i_step,
    input  wire logic [MS_W-1:0] i_dividend,
    output logic      [MS_W-1:0] o_quotient
);

    localparam int PROD_W = 2 * MS_W;
    // floor((2^MS_W - 1) / DIVISOR): estimate falls short by at most one
    localparam logic [PROD_W-1:0] RECIP_W =
        ((PROD_W'(1) << MS_W) - PROD_W'(1)) / PROD_W'(DIVISOR);
    localparam logic [MS_W-1:0] RECIP = RECIP_W[MS_W-1:0];

    typedef enum logic [1:0] {
        PH_MUL,
        PH_REM,
        PH_FIX,
        PH_DONE
    } t_div_phase;

    logic [MS_W-1:0]   r_x;
    logic [MS_W-1:0]   r_q;
    logic [MS_W-1:0]   r_rem;
    t_div_phase        r_phase;
    logic [PROD_W-1:0] prod;
    logic [MS_W-1:0]   q_mul;

    assign prod  = {{MS_W{1'b0}}, r_x} * {{MS_W{1'b0}}, RECIP};
    assign q_mul = r_q * MS_W'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_dividend;
            r_phase <= PH_MUL;
        end else if (i_step) begin
            case (r_phase)
                PH_MUL: begin
                    r_q     <= prod[PROD_W-1:MS_W];
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_rem   <= r_x - q_mul;
                    r_phase <= PH_FIX;
                end
                PH_FIX: begin
                    if (r_rem >= MS_W'(DIVISOR)) begin
                        r_q <= r_q + MS_W'(1);
                    end
                    r_phase <= PH_DONE;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_quotient = r_q;

endmodule

`default_nettype wire

FILE: rtl/dlts_datapath.sv
// Entry table, walk pointer, running sum, ID counter and dividers of the scheduler.
// Depends on dlts_pkg and dlts_div; driven by ops from dlts_ctrl.
`default_nettype none

module dlts_datapath
    import dlts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TICK_MS   = TICK_MS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_ctl  i_ctl,
    input  wire t_in_item i_item,
    output t_dp_sts       o_sts
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int DIV_STEPS = 3;
    localparam int DCNT_W = 2;

    logic [TAG_W-1:0] r_tag    [MAX_TASKS];
    logic [MS_W-1:0]  r_rel    [MAX_TASKS];
    logic [MS_W-1:0]  r_per_t  [MAX_TASKS];
    logic [ID_W-1:0]  r_id_t   [MAX_TASKS];
    logic             r_rdy    [MAX_TASKS];
    logic [TAG_W-1:0] n_tag    [MAX_TASKS];
    logic [MS_W-1:0]  n_rel    [MAX_TASKS];
    logic [MS_W-1:0]  n_per_t  [MAX_TASKS];
    logic [ID_W-1:0]  n_id_t   [MAX_TASKS];
    logic             n_rdy    [MAX_TASKS];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_next_id;
    logic [CNT_W-1:0]  r_ptr;
    logic [MS_W-1:0]   r_acc;
    logic [MS_W-1:0]   r_diff;
    logic [MS_W-1:0]   r_hold;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [ID_W-1:0]   r_new_id;
    logic [CMD_W-1:0]  r_cmd;
    logic [TAG_W-1:0]  r_new_tag;
    logic [MS_W-1:0]   r_dly;
    logic [MS_W-1:0]   r_per;
    logic [ID_W-1:0]   r_del_id;
    t_out_item         r_res;

    logic [IDX_W-1:0]  idx;
    logic [MS_W:0]     nxt;
    logic [MS_W-1:0]   dt;
    logic [MS_W-1:0]   pt;
    logic [ID_W-1:0]   id_inc;
    logic              scan_stop;
    logic              del_end;
    logic              del_match;

    dlts_div #(.DIVISOR(TICK_MS)) u_div_dly (
        .i_clk      (i_clk),
        .i_load     (i_ctl.op == DP_DIV_START),
        .i_step     (i_ctl.op == DP_DIV_STEP),
        .i_dividend (r_dly),
        .o_quotient (dt)
    );

    dlts_div #(.DIVISOR(TICK_MS)) u_div_per (
        .i_clk      (i_clk),
        .i_load     (i_ctl.op == DP_DIV_START),
        .i_step     (i_ctl.op == DP_DIV_STEP),
        .i_dividend (r_per),
        .o_quotient (pt)
    );

    assign idx       = r_ptr[IDX_W-1:0];
    assign nxt       = {1'b0, r_acc} + {1'b0, r_rel[idx]};
    assign scan_stop = (r_ptr == r_count) || ({1'b0, dt} < nxt);
    assign del_end   = (r_ptr == r_count);
    assign del_match = !del_end && (r_id_t[idx] == r_del_id);
    assign id_inc    = r_next_id + ID_W'(1);

    // Table update: shift up for insert, shift down for removal, head only for tick.
    always_comb begin
        n_count = r_count;
        for (int j = 0; j < MAX_TASKS; j++) begin
            n_tag[j]   = r_tag[j];
            n_rel[j]   = r_rel[j];
            n_per_t[j] = r_per_t[j];
            n_id_t[j]  = r_id_t[j];
            n_rdy[j]   = r_rdy[j];
        end
        case (i_ctl.op)
            DP_TICK: begin
                if (r_count != '0 && !r_rdy[0]) begin
                    if (r_rel[0] != '0) begin
                        n_rel[0] = r_rel[0] - MS_W'(1);
                    end
                    n_rdy[0] = (r_rel[0] <= MS_W'(1));
                end
            end
            DP_CLEAR: begin
                n_count = '0;
            end
            DP_INSERT: begin
                for (int j = 0; j < MAX_TASKS; j++) begin
                    if (CNT_W'(j) == r_ptr) begin
                        n_tag[j]   = r_new_tag;
                        n_rel[j]   = dt - r_acc;
                        n_per_t[j] = pt;
                        n_id_t[j]  = r_new_id;
                        n_rdy[j]   = (dt == '0);
                    end else if (CNT_W'(j) > r_ptr && CNT_W'(j) <= r_count) begin
                        n_tag[j]   = r_tag[(j > 0) ? j - 1 : 0];
                        n_rel[j]   = r_rel[(j > 0) ? j - 1 : 0];
                        n_per_t[j] = r_per_t[(j > 0) ? j - 1 : 0];
                        n_id_t[j]  = r_id_t[(j > 0) ? j - 1 : 0];
                        n_rdy[j]   = r_rdy[(j > 0) ? j - 1 : 0];
                        if (CNT_W'(j) == r_ptr + CNT_W'(1)) begin
                            n_rel[j] = r_diff;
                        end
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
            DP_POP, DP_DEL_REMOVE: begin
                for (int j = 0; j < MAX_TASKS; j++) begin
                    if (i_ctl.op == DP_POP || CNT_W'(j) >= r_ptr) begin
                        n_tag[j]   = r_tag[(j + 1 < MAX_TASKS) ? j + 1 : j];
                        n_rel[j]   = r_rel[(j + 1 < MAX_TASKS) ? j + 1 : j];
                        n_per_t[j] = r_per_t[(j + 1 < MAX_TASKS) ? j + 1 : j];
                        n_id_t[j]  = r_id_t[(j + 1 < MAX_TASKS) ? j + 1 : j];
                        n_rdy[j]   = r_rdy[(j + 1 < MAX_TASKS) ? j + 1 : j];
                    end
                end
                n_count = r_count - CNT_W'(1);
            end
            DP_DEL_FOLD: begin
                if (r_ptr < r_count) begin
                    n_rel[idx] = r_rel[idx] + r_hold;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_TASKS; j++) begin
            r_tag[j]   <= n_tag[j];
            r_rel[j]   <= n_rel[j];
            r_per_t[j] <= n_per_t[j];
            r_id_t[j]  <= n_id_t[j];
            r_rdy[j]   <= n_rdy[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= ID_FIRST;
        end else begin
            r_count <= n_count;
            if (i_ctl.op == DP_DIV_START) begin
                r_next_id <= (id_inc == '0) ? ID_FIRST : id_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            DP_LATCH: begin
                r_cmd     <= i_item.command;
                r_new_tag <= i_item.task_tag;
                r_dly     <= i_item.delay_ms;
                r_per     <= i_item.repeat_ms;
                r_del_id  <= i_item.delete_id;
                r_res     <= '0;
            end
            DP_POP: begin
                r_res.ran     <= 1'b1;
                r_res.ran_tag <= r_tag[0];
                r_new_tag     <= r_tag[0];
                r_per         <= r_per_t[0];
            end
            DP_MUL: begin
                r_dly <= MS_W'(r_per * MS_W'(TICK_MS));
                r_per <= MS_W'(r_per * MS_W'(TICK_MS));
            end
            DP_DIV_START: begin
                r_new_id  <= r_next_id;
                r_ptr     <= '0;
                r_acc     <= '0;
                r_div_cnt <= '0;
            end
            DP_DIV_STEP: begin
                r_div_cnt <= r_div_cnt + DCNT_W'(1);
            end
            DP_SCAN_STEP: begin
                if (scan_stop) begin
                    r_diff <= MS_W'(nxt - {1'b0, dt});
                end else begin
                    r_acc <= MS_W'(nxt);
                    r_ptr <= r_ptr + CNT_W'(1);
                end
            end
            DP_INSERT: begin
                r_res.assigned_id <= r_new_id;
            end
            DP_DEL_INIT: begin
                r_ptr <= '0;
            end
            DP_DEL_STEP: begin
                if (del_match) begin
                    r_hold <= r_rel[idx];
                end else begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
            end
            DP_DEL_REMOVE: begin
                r_res.deleted <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.command     = r_cmd;
    assign o_sts.tag_zero    = (r_new_tag == '0);
    assign o_sts.full        = (r_count == CNT_W'(MAX_TASKS));
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.head_ready  = r_rdy[0];
    assign o_sts.period_zero = (r_per == '0);
    assign o_sts.div_last    = (r_div_cnt == DCNT_W'(DIV_STEPS - 1));
    assign o_sts.scan_stop   = scan_stop;
    assign o_sts.del_id_zero = (r_del_id == '0);
    assign o_sts.del_end     = del_end;
    assign o_sts.del_match   = del_match;
    assign o_sts.res         = r_res;

endmodule

`default_nettype wire

FILE: rtl/dlts_ctrl.sv
// Command sequencer of the scheduler and the output beat register.
// Depends on dlts_pkg and dlts_chan_if; steers dlts_datapath.
`default_nettype none

module dlts_ctrl
    import dlts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dlts_chan_if.sink    i_in_ch,
    dlts_chan_if.source  o_out_ch,
    input  wire t_dp_sts i_sts,
    output t_dp_ctl      o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POPCK,
        S_ADDCK,
        S_DIV,
        S_SCAN,
        S_INSERT,
        S_DSCAN,
        S_DREM,
        S_DFOLD,
        S_DONE
    } t_state;

    t_state    r_state, n_state;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      out_free;

    assign out_free       = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out_data;

    always_comb begin
        n_state  = r_state;
        o_ctl.op = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid) begin
                    o_ctl.op = DP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_sts.command)
                    CMD_TICK: o_ctl.op = DP_TICK;
                    CMD_ADD:  n_state = S_ADDCK;
                    CMD_DISPATCH: begin
                        if (!i_sts.count_zero && i_sts.head_ready) begin
                            o_ctl.op = DP_POP;
                            n_state  = S_POPCK;
                        end
                    end
                    CMD_DELETE: begin
                        if (!i_sts.del_id_zero) begin
                            o_ctl.op = DP_DEL_INIT;
                            n_state  = S_DSCAN;
                        end
                    end
                    CMD_CLEAR: o_ctl.op = DP_CLEAR;
                    default: begin
                    end
                endcase
            end
            S_POPCK: begin
                // periodic entry: rebuild ms value, then add it again
                if (i_sts.period_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.op = DP_MUL;
                    n_state  = S_ADDCK;
                end
            end
            S_ADDCK: begin
                if (i_sts.tag_zero || i_sts.full) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.op = DP_DIV_START;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.op = DP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.op = DP_SCAN_STEP;
                if (i_sts.scan_stop) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_ctl.op = DP_INSERT;
                n_state  = S_DONE;
            end
            S_DSCAN: begin
                if (i_sts.del_end) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.op = DP_DEL_STEP;
                    if (i_sts.del_match) begin
                        n_state = S_DREM;
                    end
                end
            end
            S_DREM: begin
                o_ctl.op = DP_DEL_REMOVE;
                n_state  = S_DFOLD;
            end
            S_DFOLD: begin
                o_ctl.op = DP_DEL_FOLD;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_sts.res;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim/dlts_tb_scoreboard.sv
// Scoreboard for the delta-list task scheduler testbench: queue model and result check.
// Depends on dlts_pkg for the command codes and the beat types.
`timescale 1ns / 1ps

import dlts_pkg::*;

class dlts_queue_checker;
    localparam int SLOTS   = MAX_TASKS_DEF;
    localparam int TICK_LEN = TICK_MS_DEF;

    logic [TAG_W-1:0] q_tag [SLOTS];
    logic [31:0]      q_delay [SLOTS];
    logic [31:0]      q_period [SLOTS];
    logic [ID_W-1:0]  q_id [SLOTS];
    bit               q_ready [SLOTS];
    int               q_count;
    logic [ID_W-1:0]  id_counter;
    t_out_item        pending_results[$];
    int               mismatch_count;

    function void reset_state();
        q_count = 0;
        id_counter = ID_FIRST;
        pending_results.delete();
        mismatch_count = 0;
    endfunction

    function logic [ID_W-1:0] claim_id();
        logic [ID_W-1:0] id;
        id = id_counter;
        id_counter = id_counter + ID_W'(1);
        if (id_counter == '0) id_counter = ID_FIRST;
        return id;
    endfunction

    function void drop_slot(int pos);
        for (int i = pos; i + 1 < q_count; i++) begin
            q_tag[i] = q_tag[i+1];
            q_delay[i] = q_delay[i+1];
            q_period[i] = q_period[i+1];
            q_id[i] = q_id[i+1];
            q_ready[i] = q_ready[i+1];
        end
        q_count--;
    endfunction

    function logic [ID_W-1:0] insert_entry(logic [TAG_W-1:0] tag, logic [31:0] dly,
                                           logic [31:0] per);
        logic [31:0] dt;
        logic [31:0] pt;
        logic [63:0] acc;
        logic [63:0] nxt;
        int pos;
        logic [ID_W-1:0] id;
        if (tag == 0 || q_count >= SLOTS) return '0;
        dt = dly / TICK_LEN;
        pt = per / TICK_LEN;
        id = claim_id();
        acc = 0;
        pos = 0;
        while (pos < q_count) begin
            nxt = acc + q_delay[pos];
            if (64'(dt) < nxt) break;
            acc = nxt;
            pos++;
        end
        if (pos < q_count) q_delay[pos] = 32'(acc + q_delay[pos] - dt);
        for (int i = q_count; i > pos; i--) begin
            q_tag[i] = q_tag[i-1];
            q_delay[i] = q_delay[i-1];
            q_period[i] = q_period[i-1];
            q_id[i] = q_id[i-1];
            q_ready[i] = q_ready[i-1];
        end
        q_tag[pos] = tag;
        q_delay[pos] = 32'(64'(dt) - acc);
        q_period[pos] = pt;
        q_id[pos] = id;
        q_ready[pos] = (dt == 0);
        q_count++;
        return id;
    endfunction

    // Apply one accepted command beat and queue the result it must produce.
    function void note_command(t_in_item cmd);
        t_out_item res;
        logic [TAG_W-1:0] t;
        logic [31:0] pt;
        logic [31:0] pm;
        res = '0;
        case (cmd.command)
            CMD_TICK: begin
                if (q_count > 0 && !q_ready[0]) begin
                    if (q_delay[0] > 0) q_delay[0]--;
                    if (q_delay[0] == 0) q_ready[0] = 1;
                end
            end
            CMD_ADD: res.assigned_id = insert_entry(cmd.task_tag, cmd.delay_ms,
                                                     cmd.repeat_ms);
            CMD_DISPATCH: begin
                if (q_count > 0 && q_ready[0]) begin
                    t = q_tag[0];
                    pt = q_period[0];
                    res.ran = 1;
                    res.ran_tag = t;
                    drop_slot(0);
                    if (pt > 0) begin
                        pm = 32'(64'(pt) * TICK_LEN);
                        res.assigned_id = insert_entry(t, pm, pm);
                    end
                end
            end
            CMD_DELETE: begin
                if (cmd.delete_id != 0) begin
                    for (int i = 0; i < q_count; i++) begin
                        if (q_id[i] == cmd.delete_id) begin
                            if (i + 1 < q_count) q_delay[i+1] += q_delay[i];
                            drop_slot(i);
                            res.deleted = 1;
                            break;
                        end
                    end
                end
            end
            CMD_CLEAR: q_count = 0;
            default: ;
        endcase
        pending_results.push_back(res);
    endfunction

    function void check_result(t_out_item got);
        t_out_item exp;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %p", got);
            return;
        end
        exp = pending_results.pop_front();
        if (got.assigned_id !== exp.assigned_id || got.ran !== exp.ran
                || got.ran_tag !== exp.ran_tag || got.deleted !== exp.deleted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: expected %p, got %p", exp, got);
        end
    endfunction
endclass

FILE: sim/testbench.sv
// Top of the delta-list task scheduler testbench: clock, reset, drivers, checks.
// Depends on dlts_pkg, dlts_chan_if, the scheduler RTL and dlts_tb_scoreboard.
`timescale 1ns / 1ps

module testbench;
    import dlts_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;

    dlts_chan_if #(.T_DATA(t_in_item))  cmd_ch ();
    dlts_chan_if #(.T_DATA(t_out_item)) res_ch ();

    delta_list_task_scheduler_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (cmd_ch),
        .o_out_ch (res_ch)
    );

    dlts_queue_checker sched_model;
    bit  stim_done = 0;
    bit  hold_long = 0;
    int  live_ids[$];

    always #5 i_clk = ~i_clk;

    // Drive every input to a known value before the first edge.
    initial begin
        cmd_ch.valid = 0;
        cmd_ch.data = '0;
        res_ch.ready = 0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one beat, hold it until accepted, then note it in the model.
    // Valid stays high after acceptance; the next call drops it only for a gap.
    task automatic send_command(t_in_item cmd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1;
        cmd_ch.data <= cmd;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sched_model.note_command(cmd);
        if (cmd.command == CMD_ADD || cmd.command == CMD_DISPATCH)
            live_ids.push_back(sched_model.id_counter == ID_FIRST ? 255
                               : int'(sched_model.id_counter) - 1);
        if (live_ids.size() > 24) void'(live_ids.pop_front());
    endtask

    function automatic t_in_item make_cmd(logic [CMD_W-1:0] op, logic [TAG_W-1:0] tag,
                                          logic [31:0] dly, logic [31:0] per,
                                          logic [ID_W-1:0] del);
        t_in_item c;
        c.command = op;
        c.task_tag = tag;
        c.delay_ms = dly;
        c.repeat_ms = per;
        c.delete_id = del;
        return c;
    endfunction

    // Small delays keep ticks meaningful; a few draws hit the full range.
    function automatic logic [31:0] pick_ms();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(80);
        if (r < 90) return $urandom_range(400);
        return $urandom;
    endfunction

    function automatic t_in_item random_cmd();
        int r;
        logic [ID_W-1:0] del;
        r = $urandom_range(99);
        if (live_ids.size() > 0 && $urandom_range(3) != 0)
            del = ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
        else
            del = ID_W'($urandom);
        if (r < 35)
            return make_cmd(CMD_TICK, TAG_W'($urandom), $urandom, $urandom,
                            ID_W'($urandom));
        if (r < 62)
            return make_cmd(CMD_ADD, ($urandom_range(19) == 0) ? '0 : TAG_W'($urandom),
                            pick_ms(), ($urandom_range(1) == 0) ? '0 : pick_ms(),
                            ID_W'($urandom));
        if (r < 82)
            return make_cmd(CMD_DISPATCH, TAG_W'($urandom), $urandom, $urandom,
                            ID_W'($urandom));
        if (r < 94)
            return make_cmd(CMD_DELETE, TAG_W'($urandom), $urandom, $urandom, del);
        if (r < 96)
            return make_cmd(CMD_CLEAR, TAG_W'($urandom), $urandom, $urandom,
                            ID_W'($urandom));
        return make_cmd(CMD_W'($urandom_range(7, 5)), TAG_W'($urandom), $urandom,
                        $urandom, ID_W'($urandom));
    endfunction

    // Sender: reset, directed corner cases, then random traffic.
    initial begin
        sched_model = new();
        sched_model.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty-queue corners: tick, dispatch, delete with nothing held.
        send_command(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_command(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
        send_command(make_cmd(CMD_DELETE, 0, 0, 0, 8'd1));
        // Rejected add with tag zero, then sub-tick delay (ready at once).
        send_command(make_cmd(CMD_ADD, 0, 32'd50, 0, 0));
        send_command(make_cmd(CMD_ADD, 8'hFF, 32'd9, 32'd20, 0));
        send_command(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_command(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
        // Equal due times, extreme delays and periods.
        send_command(make_cmd(CMD_ADD, 8'h01, 32'd30, 0, 0));
        send_command(make_cmd(CMD_ADD, 8'h02, 32'd30, 32'hFFFF_FFFF, 0));
        send_command(make_cmd(CMD_ADD, 8'h80, 32'hFFFF_FFFF, 32'd10, 0));
        send_command(make_cmd(CMD_DELETE, 0, 0, 0, 0));
        send_command(make_cmd(CMD_DELETE, 0, 0, 0, 8'hFF));
        send_command(make_cmd(CMD_DELETE, 0, 0, 0, 8'd3));
        send_command(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
        send_command(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_command(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_command(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
        send_command(make_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        // Fill the table past capacity to hit the full-queue rejection.
        for (int i = 0; i < 18; i++)
            send_command(make_cmd(CMD_ADD, 8'(i + 1), 32'(i * 10), 0, 0));
        send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0));

        // Long receiver stall while commands keep coming.
        hold_long = 1;
        for (int i = 0; i < 12; i++) send_command(random_cmd());
        hold_long = 0;

        for (int i = 0; i < 130; i++) begin
            send_command(random_cmd());
            // Walk the ID counter past its wrap point: runs of adds, cleared every 15.
            if (i == 60) begin
                for (int k = 0; k < 225; k++) begin
                    if (k % 15 == 0) send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
                    send_command(make_cmd(CMD_ADD, 8'h5A, 32'(k), 0, 0));
                end
            end
        end
        cmd_ch.valid <= 0;
        stim_done = 1;
    end

    // Receiver: random backpressure, plus one long hold-off counted in cycles.
    initial begin
        int gap;
        bit stalled_once;
        stalled_once = 0;
        forever begin
            @(posedge i_clk);
            if (hold_long && !stalled_once) begin
                stalled_once = 1;
                res_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
            end
            gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
                res_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1;
        end
    end

    // Check every result beat at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sched_model.check_result(res_ch.data);
    end

    // Drain outstanding results, allow the slowest command to settle, then report.
    initial begin
        wait (stim_done);
        while (sched_model.pending_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sched_model.mismatch_count == 0 && sched_model.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
rtl/dlts_pkg.sv
rtl/dlts_chan_if.sv
rtl/dlts_div.sv
rtl/dlts_datapath.sv
rtl/dlts_ctrl.sv
rtl/delta_list_task_scheduler_top.sv
sim/dlts_tb_scoreboard.sv
sim/testbench.sv
